// ----- rtl/hset_pkg.sv -----
// Package for the bounded handle set: widths, request codes and control types.
package hset_pkg;

    localparam int HANDLE_W  = 32;
    localparam int TYPE_W    = 2;
    localparam int COUNT_W   = 5;
    localparam int CAP_W     = 5;
    localparam int ADDR_W    = 3;
    localparam int DATA_W    = 32;
    localparam int DEF_DEPTH = 16;

    localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

    typedef logic [TYPE_W-1:0] op_t;

    localparam op_t OP_QUERY  = 2'd0;
    localparam op_t OP_ADD    = 2'd1;
    localparam op_t OP_REMOVE = 2'd2;
    localparam op_t OP_TOGGLE = 2'd3;

    localparam logic REG_CAPACITY = 1'b0;

    typedef struct packed {
        logic start;
        logic rd_step;
        logic commit;
    } cmd_t;

    typedef struct packed {
        logic count_zero;
        logic scan_last;
        logic out_busy;
    } sts_t;

endpackage

// ----- rtl/bounded_handle_set_unit.sv -----
// Top level of the bounded handle set: register port, controller and datapath.
//
//  Channel  | Direction | Handshake          | Word
//  ---------+-----------+--------------------+-----------------------------------
//  request  | in        | in_valid/in_stall  | req_type, handle
//  result   | out       | out_valid/out_stall| member, entry_count, refused_full
//  config   | in        | APB psel/penable   | capacity at byte address 0
//
//  A request passes through the controller states idle (accept), scan (the sequential
//  search and compaction through the entry store, one held entry per step), drain (the
//  last compare) and finish (commit). With an empty set, idle goes straight to finish.
//  Reset clears the count and sets capacity to 16; the entry store is not cleared.
//  A waiting result does not block acceptance of the next request; only the commit
//  waits while the result register is still stalled.
module bounded_handle_set_unit #(
    parameter int DEPTH = hset_pkg::DEF_DEPTH
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_stall,
    input  logic [hset_pkg::TYPE_W-1:0]    req_type,
    input  logic [hset_pkg::HANDLE_W-1:0]  handle,
    output logic                           out_valid,
    input  logic                           out_stall,
    output logic                           member,
    output logic [hset_pkg::COUNT_W-1:0]   entry_count,
    output logic                           refused_full,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [hset_pkg::ADDR_W-1:0]    paddr,
    input  logic [hset_pkg::DATA_W-1:0]    pwdata,
    output logic [hset_pkg::DATA_W-1:0]    prdata,
    output logic                           pready
);

    logic [hset_pkg::CAP_W-1:0] capacity_reg;
    logic                       cfg_wr;
    hset_pkg::cmd_t             cmd;
    hset_pkg::sts_t             sts;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && (paddr[2] == hset_pkg::REG_CAPACITY);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            capacity_reg <= hset_pkg::CAP_RESET;
        end
        else if (cfg_wr)
        begin
            capacity_reg <= pwdata[hset_pkg::CAP_W-1:0];
        end
    end

    assign prdata = (paddr[2] == hset_pkg::REG_CAPACITY) ?
                    {{(hset_pkg::DATA_W - hset_pkg::CAP_W){1'b0}}, capacity_reg} : '0;

    hset_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .sts      (sts),
        .cmd      (cmd)
    );

    hset_dpath #(
        .DEPTH (DEPTH)
    ) u_dpath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .sts          (sts),
        .req_type     (req_type),
        .handle       (handle),
        .capacity     (capacity_reg),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .member       (member),
        .entry_count  (entry_count),
        .refused_full (refused_full)
    );

endmodule

// ----- rtl/hset_ctrl.sv -----
// Controller state machine that sequences the search, drain and commit of one request.
module hset_ctrl (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    output logic          in_stall,
    input  hset_pkg::sts_t sts,
    output hset_pkg::cmd_t cmd
);

    localparam logic [1:0] S_IDLE   = 2'd0;
    localparam logic [1:0] S_SCAN   = 2'd1;
    localparam logic [1:0] S_DRAIN  = 2'd2;
    localparam logic [1:0] S_FINISH = 2'd3;

    logic [1:0] state_reg;
    logic [1:0] state_next;

    always_comb
    begin
        state_next  = state_reg;
        cmd.start   = 1'b0;
        cmd.rd_step = 1'b0;
        cmd.commit  = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.start  = 1'b1;
                    state_next = sts.count_zero ? S_FINISH : S_SCAN;
                end
            end
            S_SCAN:
            begin
                cmd.rd_step = 1'b1;
                if (sts.scan_last)
                begin
                    state_next = S_DRAIN;
                end
            end
            S_DRAIN:
            begin
                state_next = S_FINISH;
            end
            S_FINISH:
            begin
                if (!sts.out_busy)
                begin
                    cmd.commit = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign in_stall = (state_reg != S_IDLE);

endmodule

// ----- rtl/hset_dpath.sv -----
// Datapath of the handle set: entry store, search compare, compaction and result register.
module hset_dpath #(
    parameter int DEPTH = hset_pkg::DEF_DEPTH
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  hset_pkg::cmd_t                 cmd,
    output hset_pkg::sts_t                 sts,
    input  hset_pkg::op_t                  req_type,
    input  logic [hset_pkg::HANDLE_W-1:0]  handle,
    input  logic [hset_pkg::CAP_W-1:0]     capacity,
    output logic                           out_valid,
    input  logic                           out_stall,
    output logic                           member,
    output logic [hset_pkg::COUNT_W-1:0]   entry_count,
    output logic                           refused_full
);

    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CMP_W = CNT_W + hset_pkg::CAP_W;
    localparam int EXT_W = CNT_W + hset_pkg::COUNT_W;

    logic [hset_pkg::HANDLE_W-1:0] mem [DEPTH];

    logic [hset_pkg::HANDLE_W-1:0] handle_reg;
    hset_pkg::op_t                 op_reg;
    logic [CNT_W-1:0]              idx_reg;
    logic [CNT_W-1:0]              idx_d_reg;
    logic                          vld_d_reg;
    logic [hset_pkg::HANDLE_W-1:0] rd_data_reg;
    logic                          found_reg;
    logic [CNT_W-1:0]              cnt_reg;
    logic [CNT_W-1:0]              cnt_next;
    logic                          out_valid_reg;
    logic                          member_reg;
    logic [hset_pkg::COUNT_W-1:0]  count_out_reg;
    logic                          refused_reg;

    logic                          hit;
    logic                          is_add;
    logic                          is_rem;
    logic                          full;
    logic                          append;
    logic                          refused;
    logic                          member_next;
    logic                          shift_wr;
    logic                          wr_en;
    logic [AW-1:0]                 wr_addr;
    logic [CNT_W-1:0]              shift_idx;
    logic [hset_pkg::HANDLE_W-1:0] wr_data;
    logic [CMP_W-1:0]              cnt_ext;
    logic [CMP_W-1:0]              cap_ext;
    logic [EXT_W-1:0]              cnt_out_ext;

    assign hit      = vld_d_reg && (rd_data_reg == handle_reg);
    assign is_add   = (op_reg == hset_pkg::OP_ADD) ||
                      ((op_reg == hset_pkg::OP_TOGGLE) && !found_reg);
    assign is_rem   = ((op_reg == hset_pkg::OP_REMOVE) || (op_reg == hset_pkg::OP_TOGGLE))
                      && found_reg;
    assign cnt_ext  = {{hset_pkg::CAP_W{1'b0}}, cnt_reg};
    assign cap_ext  = {{CNT_W{1'b0}}, capacity};
    assign full     = (cnt_ext >= cap_ext) || (cnt_reg >= CNT_W'(DEPTH));
    assign append   = is_add && !found_reg && !full;
    assign refused  = is_add && !found_reg && full;
    assign member_next = found_reg ? !is_rem : append;

    always_comb
    begin
        cnt_next = cnt_reg;
        if (append)
        begin
            cnt_next = cnt_reg + 1'b1;
        end
        else if (is_rem)
        begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    assign shift_wr  = vld_d_reg && found_reg &&
                       ((op_reg == hset_pkg::OP_REMOVE) || (op_reg == hset_pkg::OP_TOGGLE));
    assign shift_idx = idx_d_reg - 1'b1;
    assign wr_en     = (cmd.commit && append) || shift_wr;
    assign wr_addr   = (cmd.commit && append) ? cnt_reg[AW-1:0] : shift_idx[AW-1:0];
    assign wr_data   = (cmd.commit && append) ? handle_reg : rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (cmd.rd_step)
        begin
            rd_data_reg <= mem[idx_reg[AW-1:0]];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.start)
        begin
            handle_reg <= handle;
            op_reg     <= req_type;
        end
        if (cmd.rd_step)
        begin
            idx_d_reg <= idx_reg;
        end
        if (cmd.commit)
        begin
            member_reg    <= member_next;
            count_out_reg <= cnt_out_ext[hset_pkg::COUNT_W-1:0];
            refused_reg   <= refused;
        end
    end

    assign cnt_out_ext = {{hset_pkg::COUNT_W{1'b0}}, cnt_next};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg       <= '0;
            vld_d_reg     <= 1'b0;
            found_reg     <= 1'b0;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            vld_d_reg <= cmd.rd_step;
            if (cmd.start)
            begin
                idx_reg   <= '0;
                found_reg <= 1'b0;
            end
            else
            begin
                if (cmd.rd_step)
                begin
                    idx_reg <= idx_reg + 1'b1;
                end
                if (hit)
                begin
                    found_reg <= 1'b1;
                end
            end
            if (cmd.commit)
            begin
                cnt_reg       <= cnt_next;
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign sts.count_zero = (cnt_reg == '0);
    assign sts.scan_last  = (idx_reg == (cnt_reg - 1'b1));
    assign sts.out_busy   = out_valid_reg && out_stall;

    assign out_valid    = out_valid_reg;
    assign member       = member_reg;
    assign entry_count  = count_out_reg;
    assign refused_full = refused_reg;

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= CNT_W'(DEPTH))
        else $error("entry count exceeds the store depth");

    a_count_change: assert property (@(posedge clk) disable iff (!rst_n)
        (cnt_reg != $past(cnt_reg)) |-> $past(cmd.commit))
        else $error("entry count changed outside a commit");

    a_commit_slot: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.commit |-> !(out_valid_reg && out_stall))
        else $error("commit overwrote a word still waiting at the output");

    a_write_clash: assert property (@(posedge clk) disable iff (!rst_n)
        !(shift_wr && cmd.commit))
        else $error("compaction write collided with an append");

endmodule
